// ===== rtl/core/pls_pkg.sv =====
// Shared types and constants for the point light pixel shade unit.
package pls_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_LIGHT_X      = 3'd0;
    localparam logic [2:0] REG_LIGHT_Y      = 3'd1;
    localparam logic [2:0] REG_LIGHT_RADIUS = 3'd2;
    localparam logic [2:0] REG_LIGHT_FLOOR  = 3'd3;
    localparam logic [2:0] REG_ORIGIN_X     = 3'd4;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd5;
    localparam logic [2:0] REG_SCALE_X      = 3'd6;
    localparam logic [2:0] REG_SCALE_Y      = 3'd7;

    // unity brightness in Q1.8
    localparam logic [8:0] FACTOR_ONE = 9'd256;

    typedef struct packed {
        logic signed [15:0] light_x;
        logic signed [15:0] light_y;
        logic [15:0]        light_radius;
        logic [8:0]         light_floor;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [15:0]        scale_x;
        logic [15:0]        scale_y;
    } cfg_t;

endpackage

// ===== rtl/core/pls_axis.sv =====
// One axis: texel index to world coordinate, distance to the light, squared.
module pls_axis #(
    parameter int COORD_BITS = 12
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic [COORD_BITS-1:0]   idx,
    input  logic [15:0]             scale,
    input  logic signed [15:0]      origin,
    input  logic signed [15:0]      light,
    output logic [2*(((COORD_BITS+16>24)?COORD_BITS+16:24)-5)-1:0] sq
);
    localparam int PW = COORD_BITS + 16;
    localparam int QW = ((PW > 24) ? PW : 24) + 2;
    localparam int WW = QW - 8;
    localparam int DW = WW + 1;

    logic [PW-1:0]          prod_reg;
    logic signed [WW-1:0]   wx_reg;
    logic [DW-1:0]          dx_reg;
    logic [2*DW-1:0]        sq_reg;

    logic signed [QW-1:0]   q;
    logic signed [QW-1:0]   qa;
    logic signed [DW-1:0]   diff;

    // world position, truncated toward zero
    always_comb
    begin
        q    = $signed({{(QW-PW){1'b0}}, prod_reg})
             + $signed({{(QW-24){origin[15]}}, origin, 8'b0});
        qa   = q[QW-1] ? (q + $signed(QW'(255))) : q;
        diff = $signed({wx_reg[WW-1], wx_reg})
             - $signed({{(DW-16){light[15]}}, light});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PW'(idx) * PW'(scale);
            wx_reg   <= qa[QW-1:8];
            dx_reg   <= diff[DW-1] ? DW'(-diff) : DW'(diff);
            sq_reg   <= (2*DW)'(dx_reg) * (2*DW)'(dx_reg);
        end
    end

    assign sq = sq_reg;

endmodule

// ===== rtl/core/pls_isqrt.sv =====
// Pipelined integer square root, two result bits per stage.
module pls_isqrt #(
    parameter int NIT = 24
) (
    input  logic                clk,
    input  logic                en,
    input  logic [2*NIT-1:0]    v,
    output logic [NIT-1:0]      root
);
    localparam int SW  = 2 * NIT;
    localparam int NST = (NIT + 1) / 2;

    logic [SW-1:0] rem_reg [NST];
    logic [SW-1:0] res_reg [NST];
    logic [SW-1:0] rem_next [NST];
    logic [SW-1:0] res_next [NST];

    // each stage runs up to two restoring steps
    always_comb
    begin
        logic [SW-1:0] rm;
        logic [SW-1:0] rs;
        logic [SW-1:0] bt;
        int j;
        for (int s = 0; s < NST; s++)
        begin
            rm = (s == 0) ? v : rem_reg[(s == 0) ? 0 : s-1];
            rs = (s == 0) ? '0 : res_reg[(s == 0) ? 0 : s-1];
            for (int k = 0; k < 2; k++)
            begin
                j = 2*s + k;
                if (j < NIT)
                begin
                    bt = SW'(1) << (SW - 2 - 2*j);
                    if (rm >= rs + bt)
                    begin
                        rm = rm - (rs + bt);
                        rs = (rs >> 1) + bt;
                    end
                    else
                    begin
                        rs = rs >> 1;
                    end
                end
            end
            rem_next[s] = rm;
            res_next[s] = rs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NST; s++)
            begin
                rem_reg[s] <= rem_next[s];
                res_reg[s] <= res_next[s];
            end
        end
    end

    assign root = res_reg[NST-1][NIT-1:0];

endmodule

// ===== rtl/core/pls_factor.sv =====
// Distance over radius by restoring division, then the clamped brightness factor.
module pls_factor #(
    parameter int NIT = 24
) (
    input  logic            clk,
    input  logic            en,
    input  pls_pkg::cfg_t   cfg,
    input  logic [NIT-1:0]  distance,
    output logic [8:0]      factor
);
    localparam int NW = NIT + 8;

    logic           over_reg [4];
    logic [NW-1:0]  rem_reg  [4];
    logic [8:0]     quo_reg  [4];
    logic [8:0]     factor_reg;

    logic [NW-1:0]  rem_next [3];
    logic [8:0]     quo_next [3];
    logic [8:0]     fl;
    logic [9:0]     t;
    logic           over_now;

    // beyond the radius when 256*d >= 257*r
    assign over_now = {distance, 8'b0} >= (NW'(cfg.light_radius) * NW'(257));

    // three quotient bits per stage
    always_comb
    begin
        logic [NW-1:0] rm;
        logic [8:0]    qq;
        logic [NW-1:0] dv;
        for (int s = 0; s < 3; s++)
        begin
            rm = rem_reg[s];
            qq = quo_reg[s];
            for (int k = 0; k < 3; k++)
            begin
                dv = NW'({cfg.light_radius, 8'b0} >> (k + 3*s));
                if (rm >= dv)
                begin
                    rm = rm - dv;
                    qq[8 - k - 3*s] = 1'b1;
                end
            end
            rem_next[s] = rm;
            quo_next[s] = qq;
        end
    end

    // final clamp
    always_comb
    begin
        fl = (cfg.light_floor > pls_pkg::FACTOR_ONE) ? pls_pkg::FACTOR_ONE : cfg.light_floor;
        t  = {1'b0, fl} + {1'b0, pls_pkg::FACTOR_ONE} - {1'b0, quo_reg[3]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            over_reg[0] <= over_now;
            rem_reg[0]  <= {distance, 8'b0};
            quo_reg[0]  <= '0;
            for (int s = 0; s < 3; s++)
            begin
                over_reg[s+1] <= over_reg[s];
                rem_reg[s+1]  <= rem_next[s];
                quo_reg[s+1]  <= quo_next[s];
            end
            if (cfg.light_radius == 16'd0 || over_reg[3])
                factor_reg <= fl;
            else if (t > {1'b0, pls_pkg::FACTOR_ONE})
                factor_reg <= pls_pkg::FACTOR_ONE;
            else
                factor_reg <= t[8:0];
        end
    end

    assign factor = factor_reg;

endmodule

// ===== rtl/core/point_light_pixel_shade_unit.sv =====
// Root width N = max(min(COORD_BITS,12)+12, 20) bits, 24 at COORD_BITS = 12.
// Throughput: one word per cycle; the square root pipeline (two bits per stage)
// sets the depth. A stalled output holds the whole pipeline.
// Reset clears the valid bits and loads the register reset values; data
// registers are not reset.
module point_light_pixel_shade_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] texel_col,
    input  logic [11:0] texel_row,
    input  logic [7:0]  src_red,
    input  logic [7:0]  src_green,
    input  logic [7:0]  src_blue,
    input  logic [7:0]  src_alpha,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha
);
    // index bits in use, never more than the port carries
    localparam int CB  = (COORD_BITS < 12) ? COORD_BITS : 12;
    localparam int PW  = CB + 16;
    localparam int NIT = ((PW > 24) ? PW : 24) - 4;
    localparam int DW  = NIT - 1;
    localparam int NST = (NIT + 1) / 2;
    localparam int LAT = NST + 11;

    pls_pkg::cfg_t  cfg_reg;
    logic [2:0]     widx;

    logic           vld_reg [LAT];
    logic [31:0]    pix_reg [LAT-1];
    logic           en;

    logic [2*DW-1:0] sqx;
    logic [2*DW-1:0] sqy;
    logic [2*NIT-1:0] sum_reg;
    logic [NIT-1:0]  root;
    logic [8:0]      factor;
    logic [8:0]      fsel;
    logic [31:0]     pix_last;
    logic [7:0]      red_reg;
    logic [7:0]      green_reg;
    logic [7:0]      blue_reg;
    logic [7:0]      alpha_reg;

    // configuration registers
    assign pready = 1'b1;
    assign widx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_x      <= '0;
            cfg_reg.light_y      <= '0;
            cfg_reg.light_radius <= 16'd256;
            cfg_reg.light_floor  <= 9'd64;
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.scale_x      <= 16'd256;
            cfg_reg.scale_y      <= 16'd256;
        end
        else if (psel && penable && pwrite)
        begin
            case (widx)
                pls_pkg::REG_LIGHT_X:      cfg_reg.light_x      <= pwdata[15:0];
                pls_pkg::REG_LIGHT_Y:      cfg_reg.light_y      <= pwdata[15:0];
                pls_pkg::REG_LIGHT_RADIUS: cfg_reg.light_radius <= pwdata[15:0];
                pls_pkg::REG_LIGHT_FLOOR:  cfg_reg.light_floor  <= pwdata[8:0];
                pls_pkg::REG_ORIGIN_X:     cfg_reg.origin_x     <= pwdata[15:0];
                pls_pkg::REG_ORIGIN_Y:     cfg_reg.origin_y     <= pwdata[15:0];
                pls_pkg::REG_SCALE_X:      cfg_reg.scale_x      <= pwdata[15:0];
                pls_pkg::REG_SCALE_Y:      cfg_reg.scale_y      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (widx)
            pls_pkg::REG_LIGHT_X:      prdata = {16'b0, cfg_reg.light_x};
            pls_pkg::REG_LIGHT_Y:      prdata = {16'b0, cfg_reg.light_y};
            pls_pkg::REG_LIGHT_RADIUS: prdata = {16'b0, cfg_reg.light_radius};
            pls_pkg::REG_LIGHT_FLOOR:  prdata = {23'b0, cfg_reg.light_floor};
            pls_pkg::REG_ORIGIN_X:     prdata = {16'b0, cfg_reg.origin_x};
            pls_pkg::REG_ORIGIN_Y:     prdata = {16'b0, cfg_reg.origin_y};
            pls_pkg::REG_SCALE_X:      prdata = {16'b0, cfg_reg.scale_x};
            pls_pkg::REG_SCALE_Y:      prdata = {16'b0, cfg_reg.scale_y};
            default:                   prdata = '0;
        endcase
    end

    // pipeline advances unless a finished word is held
    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    // colour words ride alongside the geometry
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg[0] <= {src_red, src_green, src_blue, src_alpha};
            for (int i = 1; i < LAT-1; i++)
                pix_reg[i] <= pix_reg[i-1];
        end
    end

    pls_axis #(.COORD_BITS(CB)) u_axis_x (
        .clk    (clk),
        .en     (en),
        .idx    (texel_col[CB-1:0]),
        .scale  (cfg_reg.scale_x),
        .origin (cfg_reg.origin_x),
        .light  (cfg_reg.light_x),
        .sq     (sqx)
    );

    pls_axis #(.COORD_BITS(CB)) u_axis_y (
        .clk    (clk),
        .en     (en),
        .idx    (texel_row[CB-1:0]),
        .scale  (cfg_reg.scale_y),
        .origin (cfg_reg.origin_y),
        .light  (cfg_reg.light_y),
        .sq     (sqy)
    );

    // squared distance
    always_ff @(posedge clk)
    begin
        if (en)
            sum_reg <= (2*NIT)'(sqx) + (2*NIT)'(sqy);
    end

    pls_isqrt #(.NIT(NIT)) u_isqrt (
        .clk  (clk),
        .en   (en),
        .v    (sum_reg),
        .root (root)
    );

    pls_factor #(.NIT(NIT)) u_factor (
        .clk      (clk),
        .en       (en),
        .cfg      (cfg_reg),
        .distance (root),
        .factor   (factor)
    );

    // shade; a transparent texel takes unity and so passes unchanged
    assign pix_last = pix_reg[LAT-2];
    assign fsel     = (pix_last[7:0] == 8'd0) ? pls_pkg::FACTOR_ONE : factor;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= 8'(({9'b0, pix_last[31:24]} * {8'b0, fsel}) >> 8);
            green_reg <= 8'(({9'b0, pix_last[23:16]} * {8'b0, fsel}) >> 8);
            blue_reg  <= 8'(({9'b0, pix_last[15:8]}  * {8'b0, fsel}) >> 8);
            alpha_reg <= pix_last[7:0];
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign out_alpha = alpha_reg;

endmodule

// ===== rtl/core/pls_checker.sv =====
// Port-level checks for the shade unit, bound to the top level.
module pls_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_red,
    input logic [7:0] out_alpha
);
    // a held word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // a held word keeps its red and alpha bytes
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_red) && $stable(out_alpha))
        else $error("output word changed while stalled");

    // input is ready exactly when the output register can move
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready out of step with output stage");

    // register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind point_light_pixel_shade_unit pls_checker u_pls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_alpha (out_alpha)
);
